@@ rtl/aaq_pkg.sv @@
// Shared types, constants and tables for the rotation vector to quaternion block.
`default_nettype none

package aaq_pkg;

   localparam int CORDIC_ITERATIONS = 24;
   localparam int SQRT_STAGES       = 32;
   localparam int DIV_STAGES        = 32;
   localparam int MOD_STAGES        = 5;
   localparam int QUEUE_AW          = 2;
   localparam int QUEUE_DEPTH       = 1 << QUEUE_AW;

   localparam logic [15:0]        THRESHOLD_RESET = 16'd17;
   localparam logic signed [31:0] Q30_ONE         = 32'sd1073741824;
   localparam logic signed [33:0] CORDIC_GAIN     = 34'sd652032874;
   localparam logic signed [36:0] PI_Q32          = 37'sd13493037705;
   localparam logic signed [36:0] HALF_PI_Q32     = 37'sd6746518852;
   localparam logic signed [36:0] TWO_PI_Q32      = 37'sd26986075409;
   localparam logic [38:0]        TWO_PI_WIDE     = 39'd26986075409;

   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic [31:0]        norm;
      logic               ident;
   } item_type;

   function automatic logic signed [33:0] atan_q30(input int idx);
      logic signed [33:0] v;
      case (idx)
         0: v = 34'sd843314857;
         1: v = 34'sd497837830;
         2: v = 34'sd263043837;
         3: v = 34'sd133525159;
         4: v = 34'sd67021687;
         5: v = 34'sd33543516;
         6: v = 34'sd16775851;
         7: v = 34'sd8388437;
         8: v = 34'sd4194283;
         9: v = 34'sd2097149;
         10: v = 34'sd1048576;
         11: v = 34'sd524288;
         12: v = 34'sd262144;
         13: v = 34'sd131072;
         14: v = 34'sd65536;
         15: v = 34'sd32768;
         16: v = 34'sd16384;
         17: v = 34'sd8192;
         18: v = 34'sd4096;
         19: v = 34'sd2048;
         20: v = 34'sd1024;
         21: v = 34'sd512;
         22: v = 34'sd256;
         23: v = 34'sd128;
         24: v = 34'sd64;
         25: v = 34'sd32;
         26: v = 34'sd16;
         27: v = 34'sd8;
         28: v = 34'sd4;
         29: v = 34'sd2;
         30: v = 34'sd1;
         default: v = 34'sd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

@@ rtl/aaq_front.sv @@
// Front pipeline: sum of squares, pipelined square root and small angle classification.
`default_nettype none

module aaq_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic signed [31:0] in_x,
   input  wire logic signed [31:0] in_y,
   input  wire logic signed [31:0] in_z,
   input  wire logic [15:0]        threshold,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output aaq_pkg::item_type       out_item
);

   localparam int Sq   = aaq_pkg::SQRT_STAGES;
   localparam int Last = Sq + 2;

   logic [Last:0]      vld_ff;
   aaq_pkg::item_type  item_ff [0:Last];
   logic [63:0]        sq_ff [0:2];
   logic [63:0]        sv_ff [0:Sq];
   logic [63:0]        sr_ff [0:Sq];
   logic [63:0]        sv_in [1:Sq];
   logic [63:0]        sr_in [1:Sq];
   logic [31:0]        mag [0:2];
   logic signed [31:0] cmp [0:2];
   logic               en;

   assign en       = !vld_ff[Last] || out_ready;
   assign in_ready = en;

   always_comb begin
      cmp[0] = item_ff[0].cx;
      cmp[1] = item_ff[0].cy;
      cmp[2] = item_ff[0].cz;
      for (int k = 0; k < 3; k++) begin
         mag[k] = cmp[k][31] ? (~cmp[k] + 32'd1) : cmp[k];
      end
   end

   always_comb begin
      logic [63:0] bitv;
      logic [63:0] trial;
      for (int i = 0; i < Sq; i++) begin
         bitv  = 64'd1 << (62 - 2 * i);
         trial = sr_ff[i] + bitv;
         if (sv_ff[i] >= trial) begin
            sv_in[i+1] = sv_ff[i] - trial;
            sr_in[i+1] = (sr_ff[i] >> 1) + bitv;
         end else begin
            sv_in[i+1] = sv_ff[i];
            sr_in[i+1] = sr_ff[i] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[Last-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff[0] <= '{cx: in_x, cy: in_y, cz: in_z, norm: 32'd0, ident: 1'b0};
         for (int k = 1; k <= Last; k++) begin
            item_ff[k] <= item_ff[k-1];
         end
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= mag[k] * mag[k];
         end
         sv_ff[0] <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         sr_ff[0] <= '0;
         for (int i = 1; i <= Sq; i++) begin
            sv_ff[i] <= sv_in[i];
            sr_ff[i] <= sr_in[i];
         end
      end
   end

   always_comb begin
      out_valid      = vld_ff[Last];
      out_item       = item_ff[Last];
      out_item.norm  = sr_ff[Sq][31:0];
      out_item.ident = sr_ff[Sq][31:0] <= {16'd0, threshold};
   end

endmodule

`default_nettype wire

@@ rtl/aaq_queue.sv @@
// Short queue that decouples the front pipeline from the back pipeline.
`default_nettype none

module aaq_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire aaq_pkg::item_type in_item,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output aaq_pkg::item_type      out_item
);

   localparam int Aw    = aaq_pkg::QUEUE_AW;
   localparam int Depth = aaq_pkg::QUEUE_DEPTH;

   aaq_pkg::item_type mem_ff [0:Depth-1];
   logic [Aw-1:0]     wr_ff;
   logic [Aw-1:0]     rd_ff;
   logic [Aw:0]       cnt_ff;
   logic              push;
   logic              pop;

   assign in_ready  = cnt_ff != (Aw+1)'(Depth);
   assign out_valid = cnt_ff != '0;
   assign out_item  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

endmodule

`default_nettype wire

@@ rtl/aaq_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module aaq_div (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [61:0] num,
   input  wire logic [31:0] den,
   output logic [31:0]      quo
);

   localparam int N = aaq_pkg::DIV_STAGES;

   logic [61:0] rem_ff [1:N];
   logic [31:0] den_ff [1:N];
   logic [31:0] quo_ff [1:N];
   logic [61:0] rem_in [1:N];
   logic [31:0] quo_in [1:N];

   always_comb begin
      logic [63:0] trial;
      logic [61:0] r;
      logic [31:0] d;
      logic [31:0] q;
      for (int j = 1; j <= N; j++) begin
         r     = (j == 1) ? num : rem_ff[(j > 1) ? j - 1 : 1];
         d     = (j == 1) ? den : den_ff[(j > 1) ? j - 1 : 1];
         q     = (j == 1) ? 32'd0 : quo_ff[(j > 1) ? j - 1 : 1];
         trial = {32'd0, d} << (N - j);
         if ({2'b00, r} >= trial) begin
            rem_in[j] = r - trial[61:0];
            quo_in[j] = q | (32'd1 << (N - j));
         end else begin
            rem_in[j] = r;
            quo_in[j] = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 1; j <= N; j++) begin
            rem_ff[j] <= rem_in[j];
            quo_ff[j] <= quo_in[j];
            den_ff[j] <= (j == 1) ? den : den_ff[(j > 1) ? j - 1 : 1];
         end
      end
   end

   assign quo = quo_ff[N];

endmodule

`default_nettype wire

@@ rtl/aaq_back.sv @@
// Back pipeline: angle reduction, CORDIC, scaling by sine over norm and output register.
`default_nettype none

module aaq_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire aaq_pkg::item_type in_item,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic signed [31:0]     quat_x,
   output logic signed [31:0]     quat_y,
   output logic signed [31:0]     quat_z,
   output logic signed [31:0]     quat_w,
   output logic                   identity_used
);

   localparam int N     = aaq_pkg::CORDIC_ITERATIONS;
   localparam int Mod   = aaq_pkg::MOD_STAGES;
   localparam int Dv    = aaq_pkg::DIV_STAGES;
   localparam int SFold = Mod + 1;
   localparam int SSat  = SFold + N + 1;
   localparam int SMul  = SSat + 1;
   localparam int SRnd  = SMul + 1;
   localparam int SOut  = SRnd + Dv + 1;

   typedef struct packed {
      logic               ident;
      logic [2:0]         neg;
      logic signed [31:0] cosv;
   } tail_type;

   logic [SOut:0]      vld_ff;
   aaq_pkg::item_type  item_ff [0:SRnd];
   logic [38:0]        ang_ff [1:Mod];
   logic [38:0]        ang_in [1:Mod];
   logic signed [33:0] x_ff [0:N];
   logic signed [33:0] y_ff [0:N];
   logic signed [33:0] z_ff [0:N];
   logic               cn_ff [0:N];
   logic signed [33:0] x_in [1:N];
   logic signed [33:0] y_in [1:N];
   logic signed [33:0] z_in [1:N];
   logic signed [31:0] cos_ff;
   logic signed [31:0] sin_ff;
   logic signed [31:0] cosm_ff;
   logic signed [63:0] prod_ff [0:2];
   logic [61:0]        num_ff [0:2];
   tail_type           tail_ff [0:Dv];
   logic [31:0]        quo [0:2];
   logic signed [31:0] res [0:2];
   logic signed [31:0] cmp [0:2];
   logic signed [36:0] r0;
   logic signed [36:0] r1;
   logic signed [36:0] r2;
   logic signed [36:0] zq;
   logic               cneg;
   logic signed [33:0] xs;
   logic signed [31:0] out_x_ff;
   logic signed [31:0] out_y_ff;
   logic signed [31:0] out_z_ff;
   logic signed [31:0] out_w_ff;
   logic               out_id_ff;
   logic               en;

   function automatic logic signed [31:0] sat_q30(input logic signed [33:0] v);
      logic signed [31:0] s;
      if (v > 34'sd1073741824) begin
         s = aaq_pkg::Q30_ONE;
      end else if (v < -34'sd1073741824) begin
         s = -aaq_pkg::Q30_ONE;
      end else begin
         s = v[31:0];
      end
      return s;
   endfunction

   assign en       = !vld_ff[SOut] || out_ready;
   assign in_ready = en;

   always_comb begin
      for (int k = 1; k <= Mod; k++) begin
         logic [38:0] src;
         logic [38:0] sub;
         src = (k == 1) ? {item_ff[0].norm, 7'd0} : ang_ff[(k > 1) ? k - 1 : 1];
         sub = aaq_pkg::TWO_PI_WIDE << (Mod - k);
         ang_in[k] = (src >= sub) ? src - sub : src;
      end
   end

   always_comb begin
      r0   = $signed({2'b00, ang_ff[Mod][34:0]});
      r1   = (r0 > aaq_pkg::PI_Q32) ? r0 - aaq_pkg::TWO_PI_Q32 : r0;
      cneg = 1'b0;
      r2   = r1;
      if (r1 > aaq_pkg::HALF_PI_Q32) begin
         r2   = aaq_pkg::PI_Q32 - r1;
         cneg = 1'b1;
      end else if (r1 < -aaq_pkg::HALF_PI_Q32) begin
         r2   = -aaq_pkg::PI_Q32 - r1;
         cneg = 1'b1;
      end
      zq = r2 >>> 2;
   end

   always_comb begin
      for (int i = 0; i < N; i++) begin
         if (z_ff[i] >= 0) begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - aaq_pkg::atan_q30(i);
         end else begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + aaq_pkg::atan_q30(i);
         end
      end
   end

   always_comb begin
      xs     = cn_ff[N] ? -x_ff[N] : x_ff[N];
      cmp[0] = item_ff[SSat].cx;
      cmp[1] = item_ff[SSat].cy;
      cmp[2] = item_ff[SSat].cz;
   end

   for (genvar k = 0; k < 3; k++) begin : g_lane
      aaq_div u_div (
         .clock (clock),
         .en    (en),
         .num   (num_ff[k]),
         .den   (item_ff[SRnd].norm),
         .quo   (quo[k])
      );
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic [31:0] qs;
         qs     = (quo[k] > 32'd1073741824) ? 32'd1073741824 : quo[k];
         res[k] = tail_ff[Dv].neg[k] ? -$signed(qs) : $signed(qs);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[SOut-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff[0] <= in_item;
         for (int k = 1; k <= SRnd; k++) begin
            item_ff[k] <= item_ff[k-1];
         end
         for (int k = 1; k <= Mod; k++) begin
            ang_ff[k] <= ang_in[k];
         end
         x_ff[0]  <= aaq_pkg::CORDIC_GAIN;
         y_ff[0]  <= '0;
         z_ff[0]  <= zq[33:0];
         cn_ff[0] <= cneg;
         for (int i = 1; i <= N; i++) begin
            x_ff[i]  <= x_in[i];
            y_ff[i]  <= y_in[i];
            z_ff[i]  <= z_in[i];
            cn_ff[i] <= cn_ff[i-1];
         end
         cos_ff  <= sat_q30(xs);
         sin_ff  <= sat_q30(y_ff[N]);
         cosm_ff <= cos_ff;
         for (int k = 0; k < 3; k++) begin
            logic [63:0] m;
            prod_ff[k] <= cmp[k] * sin_ff;
            m = prod_ff[k][63] ? -prod_ff[k] : prod_ff[k];
            num_ff[k] <= m[61:0] + {31'd0, item_ff[SMul].norm[31:1]};
         end
         tail_ff[0] <= '{ident: item_ff[SMul].ident,
                         neg: {prod_ff[2][63], prod_ff[1][63], prod_ff[0][63]},
                         cosv: cosm_ff};
         for (int k = 1; k <= Dv; k++) begin
            tail_ff[k] <= tail_ff[k-1];
         end
         if (tail_ff[Dv].ident) begin
            out_x_ff <= '0;
            out_y_ff <= '0;
            out_z_ff <= '0;
            out_w_ff <= aaq_pkg::Q30_ONE;
         end else begin
            out_x_ff <= res[0];
            out_y_ff <= res[1];
            out_z_ff <= res[2];
            out_w_ff <= tail_ff[Dv].cosv;
         end
         out_id_ff <= tail_ff[Dv].ident;
      end
   end

   assign out_valid     = vld_ff[SOut];
   assign quat_x        = out_x_ff;
   assign quat_y        = out_y_ff;
   assign quat_z        = out_z_ff;
   assign quat_w        = out_w_ff;
   assign identity_used = out_id_ff;

endmodule

`default_nettype wire

@@ rtl/axis_angle_to_quaternion.sv @@
// Top level of the rotation vector to unit quaternion converter.
// Throughput: one item per cycle while the response side accepts, set by the fully pipelined
// 32 stage square root, the CORDIC stages and three 32 stage dividers in the back pipeline.
// Reset clears all valid bits and queue pointers and loads the threshold with 17.
// No memory clearing pass follows reset.
`default_nettype none

module axis_angle_to_quaternion (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_rot_x,
   input  wire logic signed [31:0] req_rot_y,
   input  wire logic signed [31:0] req_rot_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_quat_x,
   output logic signed [31:0]      rsp_quat_y,
   output logic signed [31:0]      rsp_quat_z,
   output logic signed [31:0]      rsp_quat_w,
   output logic                    rsp_identity_used,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [15:0]        csr_wdata
);

   logic [15:0]       thr_ff;
   logic              f_valid;
   logic              f_ready;
   aaq_pkg::item_type f_item;
   logic              q_valid;
   logic              q_ready;
   aaq_pkg::item_type q_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= aaq_pkg::THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_wdata;
      end
   end

   aaq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_x      (req_rot_x),
      .in_y      (req_rot_y),
      .in_z      (req_rot_z),
      .threshold (thr_ff),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_item  (f_item)
   );

   aaq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   aaq_back u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (q_valid),
      .in_ready      (q_ready),
      .in_item       (q_item),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .quat_x        (rsp_quat_x),
      .quat_y        (rsp_quat_y),
      .quat_z        (rsp_quat_z),
      .quat_w        (rsp_quat_w),
      .identity_used (rsp_identity_used)
   );

   a_identity_value : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_identity_used |->
         rsp_quat_x == 32'sd0 && rsp_quat_y == 32'sd0 && rsp_quat_z == 32'sd0 &&
         rsp_quat_w == aaq_pkg::Q30_ONE)
      else $error("identity item with non-identity quaternion");

   a_w_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_quat_w <= aaq_pkg::Q30_ONE && rsp_quat_w >= -aaq_pkg::Q30_ONE)
      else $error("scalar part outside saturation range");

   a_reset_idle : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire
